>>> rtl/core/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, character codes and character-class helpers of the token
// lexer: the result record and the functions that classify one source byte.
// ----------------------------------------------------------------------------
package stl_pkg;

	// Token type codes
	localparam logic [2:0] TT_PUNCT    = 3'd0;
	localparam logic [2:0] TT_OPERATOR = 3'd1;
	localparam logic [2:0] TT_STRING   = 3'd2;
	localparam logic [2:0] TT_FORMAT   = 3'd3;
	localparam logic [2:0] TT_IDENT    = 3'd4;
	localparam logic [2:0] TT_NUMBER   = 3'd5;
	localparam logic [2:0] TT_UNDEF    = 3'd6;
	localparam logic [2:0] TT_END      = 3'd7;

	// Result kinds
	localparam logic RK_VALUE = 1'b0;
	localparam logic RK_TOKEN = 1'b1;

	// Character codes
	localparam logic [7:0] CH_EQ     = 8'h3D; // =
	localparam logic [7:0] CH_LT     = 8'h3C; // <
	localparam logic [7:0] CH_GT     = 8'h3E; // >
	localparam logic [7:0] CH_PLUS   = 8'h2B; // +
	localparam logic [7:0] CH_MINUS  = 8'h2D; // -
	localparam logic [7:0] CH_STAR   = 8'h2A; // *
	localparam logic [7:0] CH_SLASH  = 8'h2F; // /
	localparam logic [7:0] CH_PCT    = 8'h25; // %
	localparam logic [7:0] CH_BTICK  = 8'h60; // backtick
	localparam logic [7:0] CH_DQUOTE = 8'h22; // double quote
	localparam logic [7:0] CH_UNDER  = 8'h5F; // _

	// Largest accumulator value that still takes one more digit:
	// floor((2^64-1-d)/10), for digits 0..5 and 6..9
	localparam logic [63:0] ACC_LIM_LOW  = 64'd1844674407370955161;
	localparam logic [63:0] ACC_LIM_HIGH = 64'd1844674407370955160;

	// One result item
	typedef struct packed {
		logic        kind;
		logic [7:0]  value_char;
		logic [2:0]  token_type;
		logic [15:0] short_text;
		logic [1:0]  short_length;
		logic [15:0] token_length;
		logic [63:0] number_value;
		logic        number_overflow;
		logic        last;
	} res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	// ( ) { } [ ] : , ; ~ ^ # $ ? ! @ . & |
	function automatic logic is_punct(input logic [7:0] c);
		logic hit;
		hit = 1'b0;
		unique case (c)
			8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3A, 8'h2C, 8'h3B,
			8'h7E, 8'h5E, 8'h23, 8'h24, 8'h3F, 8'h21, 8'h40, 8'h2E, 8'h26,
			8'h7C: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic is_op_start(input logic [7:0] c);
		return (c == CH_EQ) || (c == CH_LT) || (c == CH_GT) || (c == CH_PLUS) ||
			(c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) || (c == CH_PCT);
	endfunction

	// Second character that turns a one-character operator into a pair
	function automatic logic op_extends(input logic [7:0] first, input logic [7:0] c);
		logic ext;
		ext = 1'b0;
		if (c == CH_EQ) begin
			ext = 1'b1;
		end else if (first == CH_EQ) begin
			ext = (c == CH_GT);
		end else if (first == CH_PLUS) begin
			ext = (c == CH_PLUS);
		end else if (first == CH_MINUS) begin
			ext = (c == CH_MINUS) || (c == CH_GT);
		end
		return ext;
	endfunction

	function automatic res_t mk_value(input logic [7:0] c);
		res_t r;
		r = '0;
		r.kind       = RK_VALUE;
		r.value_char = c;
		return r;
	endfunction

	function automatic res_t mk_short(input logic [2:0] tt, input logic [15:0] text,
		input logic [1:0] len);
		res_t r;
		r = '0;
		r.kind         = RK_TOKEN;
		r.token_type   = tt;
		r.short_text   = text;
		r.short_length = len;
		return r;
	endfunction

	function automatic res_t mk_token(input logic [2:0] tt, input logic [15:0] len,
		input logic [63:0] num, input logic ovf);
		res_t r;
		r = '0;
		r.kind            = RK_TOKEN;
		r.token_type      = tt;
		r.token_length    = len;
		r.number_value    = num;
		r.number_overflow = ovf;
		return r;
	endfunction

endpackage

>>> rtl/core/stl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_core
// Lexer state and next-state logic. For the character in the input register
// it forms up to two results and the next lexer state, and commits the state
// on step.
// ----------------------------------------------------------------------------
module stl_core
	import stl_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] char_in,
	input  logic       eoi,
	output res_t       res0,
	output res_t       res1,
	output logic [1:0] res_cnt
);

	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_IDENT   = 3'd1;
	localparam logic [2:0] M_NUM     = 3'd2;
	localparam logic [2:0] M_STR     = 3'd3;
	localparam logic [2:0] M_OP      = 3'd4;
	localparam logic [2:0] M_COMMENT = 3'd5;

	logic [2:0]             mode_q, mode_d;
	logic                   bt_q, bt_d;
	logic [15:0]            op_text_q, op_text_d;
	logic [1:0]             op_len_q, op_len_d;
	logic [63:0]            accum_q, accum_d;
	logic                   ovf_q, ovf_d;
	logic [LENGTH_BITS-1:0] count_q, count_d;
	logic                   star_q, star_d;

	logic [15:0]            len_out;
	logic [LENGTH_BITS-1:0] count_inc;
	logic [3:0]             digit;
	logic [63:0]            acc_lim;
	logic [63:0]            acc_next;
	logic                   acc_ovf;

	// state after a character lexed from idle
	logic [2:0]             i_mode;
	logic                   i_bt;
	logic [15:0]            i_op_text;
	logic [1:0]             i_op_len;
	logic [63:0]            i_accum;
	logic [LENGTH_BITS-1:0] i_count;
	logic                   i_has;
	res_t                   i_res;

	logic                   f_has;
	res_t                   f_res;

	logic                   a_has, b_has;
	res_t                   a_res, b_res;

	// Map the length counter onto the 16-bit result field
	generate
		if (LENGTH_BITS >= 16) begin : g_len_trunc
			assign len_out = count_q[15:0];
		end else begin : g_len_ext
			assign len_out = {{(16-LENGTH_BITS){1'b0}}, count_q};
		end
	endgenerate

	// Saturating length increment
	assign count_inc = (count_q == {LENGTH_BITS{1'b1}}) ? count_q :
		count_q + LENGTH_BITS'(1);

	// Decimal accumulate with saturation
	assign digit    = char_in[3:0];
	assign acc_lim  = (digit <= 4'd5) ? ACC_LIM_LOW : ACC_LIM_HIGH;
	assign acc_ovf  = ovf_q || (accum_q > acc_lim);
	assign acc_next = acc_ovf ? {64{1'b1}} :
		({accum_q[60:0], 3'b000} + {accum_q[62:0], 1'b0} + {60'd0, digit});

	// Lex the character from the idle state
	always_comb begin
		i_mode    = M_IDLE;
		i_bt      = 1'b0;
		i_op_text = '0;
		i_op_len  = '0;
		i_accum   = '0;
		i_count   = '0;
		i_has     = 1'b0;
		i_res     = '0;
		priority if (is_punct(char_in)) begin
			i_has = 1'b1;
			i_res = mk_short(TT_PUNCT, {8'd0, char_in}, 2'd1);
		end else if (is_op_start(char_in)) begin
			i_mode    = M_OP;
			i_op_text = {8'd0, char_in};
			i_op_len  = 2'd1;
		end else if ((char_in == CH_BTICK) || (char_in == CH_DQUOTE)) begin
			i_mode = M_STR;
			i_bt   = (char_in == CH_BTICK);
		end else if (is_space(char_in)) begin
			i_mode = M_IDLE;
		end else if (is_digit(char_in)) begin
			i_mode  = M_NUM;
			i_accum = {60'd0, digit};
			i_count = LENGTH_BITS'(1);
			i_has   = 1'b1;
			i_res   = mk_value(char_in);
		end else if (is_alpha(char_in) || (char_in == CH_UNDER)) begin
			i_mode  = M_IDENT;
			i_count = LENGTH_BITS'(1);
			i_has   = 1'b1;
			i_res   = mk_value(char_in);
		end else begin
			i_has = 1'b1;
			i_res = mk_short(TT_UNDEF, {8'd0, char_in}, 2'd1);
		end
	end

	// Token that a pending identifier, number or operator closes with
	always_comb begin
		f_has = 1'b0;
		f_res = '0;
		unique case (mode_q)
			M_IDENT: begin
				f_has = 1'b1;
				f_res = mk_token(TT_IDENT, len_out, 64'd0, 1'b0);
			end
			M_NUM: begin
				f_has = 1'b1;
				f_res = mk_token(TT_NUMBER, len_out, accum_q, ovf_q);
			end
			M_OP: begin
				f_has = 1'b1;
				f_res = mk_short(TT_OPERATOR, op_text_q, op_len_q);
			end
			default: begin
				f_has = 1'b0;
			end
		endcase
	end

	// Next state and the two result slots
	always_comb begin
		mode_d    = mode_q;
		bt_d      = bt_q;
		op_text_d = op_text_q;
		op_len_d  = op_len_q;
		accum_d   = accum_q;
		ovf_d     = ovf_q;
		count_d   = count_q;
		star_d    = star_q;
		a_has     = 1'b0;
		a_res     = '0;
		b_has     = 1'b0;
		b_res     = '0;
		if (eoi) begin
			// flush, clear, then the end token
			a_has     = f_has;
			a_res     = f_res;
			b_has     = 1'b1;
			b_res     = mk_short(TT_END, 16'd0, 2'd0);
			mode_d    = M_IDLE;
			bt_d      = 1'b0;
			op_text_d = '0;
			op_len_d  = '0;
			accum_d   = '0;
			ovf_d     = 1'b0;
			count_d   = '0;
			star_d    = 1'b0;
		end else begin
			unique case (mode_q)
				M_IDENT, M_NUM, M_STR, M_OP, M_COMMENT, M_IDLE: begin
					// default: lex from idle, flushing the pending token
					a_has     = f_has;
					a_res     = f_res;
					b_has     = i_has;
					b_res     = i_res;
					mode_d    = i_mode;
					bt_d      = i_bt;
					op_text_d = i_op_text;
					op_len_d  = i_op_len;
					accum_d   = i_accum;
					ovf_d     = 1'b0;
					count_d   = i_count;
					star_d    = 1'b0;
					if ((mode_q == M_IDENT) && (is_alpha(char_in) || is_digit(char_in) ||
						(char_in == CH_UNDER))) begin
						a_has     = 1'b0;
						b_has     = 1'b1;
						b_res     = mk_value(char_in);
						mode_d    = mode_q;
						op_text_d = op_text_q;
						op_len_d  = op_len_q;
						accum_d   = accum_q;
						ovf_d     = ovf_q;
						bt_d      = bt_q;
						count_d   = count_inc;
					end else if ((mode_q == M_NUM) && is_digit(char_in)) begin
						a_has     = 1'b0;
						b_has     = 1'b1;
						b_res     = mk_value(char_in);
						mode_d    = mode_q;
						op_text_d = op_text_q;
						op_len_d  = op_len_q;
						accum_d   = acc_next;
						ovf_d     = acc_ovf;
						bt_d      = bt_q;
						count_d   = count_inc;
					end else if (mode_q == M_STR) begin
						a_has = 1'b0;
						if (char_in == (bt_q ? CH_BTICK : CH_DQUOTE)) begin
							b_has     = 1'b1;
							b_res     = mk_token(bt_q ? TT_FORMAT : TT_STRING, len_out,
								64'd0, 1'b0);
							mode_d    = M_IDLE;
							bt_d      = 1'b0;
							op_text_d = '0;
							op_len_d  = '0;
							accum_d   = '0;
							count_d   = '0;
						end else begin
							b_has     = 1'b1;
							b_res     = mk_value(char_in);
							mode_d    = mode_q;
							bt_d      = bt_q;
							op_text_d = op_text_q;
							op_len_d  = op_len_q;
							accum_d   = accum_q;
							ovf_d     = ovf_q;
							count_d   = count_inc;
							star_d    = star_q;
						end
					end else if ((mode_q == M_OP) && (op_len_q == 2'd1) &&
						(op_text_q == {8'd0, CH_SLASH}) && (char_in == CH_STAR)) begin
						// open a block comment, no operator token
						a_has     = 1'b0;
						b_has     = 1'b0;
						mode_d    = M_COMMENT;
						bt_d      = 1'b0;
						op_text_d = '0;
						op_len_d  = '0;
						accum_d   = '0;
						count_d   = '0;
					end else if ((mode_q == M_OP) && (op_len_q == 2'd1) &&
						op_extends(op_text_q[7:0], char_in)) begin
						a_has     = 1'b0;
						b_has     = 1'b0;
						mode_d    = mode_q;
						bt_d      = bt_q;
						op_text_d = {char_in, op_text_q[7:0]};
						op_len_d  = 2'd2;
						accum_d   = accum_q;
						ovf_d     = ovf_q;
						count_d   = count_q;
					end else if (mode_q == M_COMMENT) begin
						a_has = 1'b0;
						b_has = 1'b0;
						if (star_q && (char_in == CH_SLASH)) begin
							mode_d = M_IDLE;
							star_d = 1'b0;
						end else begin
							mode_d    = mode_q;
							star_d    = (char_in == CH_STAR);
						end
						bt_d      = 1'b0;
						op_text_d = '0;
						op_len_d  = '0;
						accum_d   = '0;
						count_d   = '0;
					end
				end
				default: begin
					a_has     = 1'b0;
					b_has     = i_has;
					b_res     = i_res;
					mode_d    = i_mode;
					bt_d      = i_bt;
					op_text_d = i_op_text;
					op_len_d  = i_op_len;
					accum_d   = i_accum;
					ovf_d     = 1'b0;
					count_d   = i_count;
					star_d    = 1'b0;
				end
			endcase
		end
	end

	// Pack the results into order and mark the last one
	always_comb begin
		res0    = '0;
		res1    = '0;
		res_cnt = 2'd0;
		if (a_has) begin
			res0    = a_res;
			res1    = b_res;
			res_cnt = b_has ? 2'd2 : 2'd1;
		end else if (b_has) begin
			res0    = b_res;
			res_cnt = 2'd1;
		end
		res0.last = (res_cnt == 2'd1);
		res1.last = (res_cnt == 2'd2);
	end

	// Commit the lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			bt_q      <= 1'b0;
			op_text_q <= '0;
			op_len_q  <= '0;
			accum_q   <= '0;
			ovf_q     <= 1'b0;
			count_q   <= '0;
			star_q    <= 1'b0;
		end else if (step) begin
			mode_q    <= mode_d;
			bt_q      <= bt_d;
			op_text_q <= op_text_d;
			op_len_q  <= op_len_d;
			accum_q   <= accum_d;
			ovf_q     <= ovf_d;
			count_q   <= count_d;
			star_q    <= star_d;
		end
	end

endmodule

>>> rtl/core/stl_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_out_buf
// Two-entry result register. Loads all results of one character at once and
// presents them one transfer at a time.
// ----------------------------------------------------------------------------
module stl_out_buf
	import stl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_t       res0,
	input  res_t       res1,
	input  logic [1:0] res_cnt,
	input  logic       pop_ready,
	output logic       can_load,
	output logic       head_valid,
	output res_t       head
);

	res_t       slot0_q, slot1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign head_valid = (cnt_q != 2'd0);
	assign head       = slot0_q;
	assign pop        = head_valid && pop_ready;
	assign can_load   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop_ready);

	// Count of held results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Load new results or advance the second slot to the head
	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= res0;
			slot1_q <= res1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

>>> rtl/core/source_token_lexer_unit.sv
`timescale 1ns / 1ps
// A character waits in the input register; its results are then registered in the result register.
// Throughput: one character per cycle while the output accepts results; a character that yields two
// results holds the next character in the input register while the result register drains.
// The two-entry result register and the input register set this rate.
// Reset: arst_n clears the lexer state to idle and empties both registers.
// ----------------------------------------------------------------------------
// source_token_lexer_unit
// Character-serial tokenizer: one source byte per transfer in, a stream of
// value-character and token results out.
// ----------------------------------------------------------------------------
module source_token_lexer_unit
	import stl_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] in_char
	input  logic         s_tlast,  // end_of_input
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,  // [7:0] value_char, [10:8] token_type,
	                               // [26:11] short_text, [28:27] short_length,
	                               // [44:29] token_length, [108:45] number_value,
	                               // [109] number_overflow, [111:110] zero
	output logic         m_tuser,  // result_kind
	output logic         m_tlast   // last_result
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;
	logic       step;
	logic       can_load;
	logic [1:0] res_cnt;
	res_t       res0, res1, head;

	assign step     = valid_s1 && can_load;
	assign s_tready = !valid_s1 || step;

	// Input register: hold a character until the lexer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	stl_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.char_in (char_s1),
		.eoi     (eoi_s1),
		.res0    (res0),
		.res1    (res1),
		.res_cnt (res_cnt)
	);

	stl_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (step),
		.res0       (res0),
		.res1       (res1),
		.res_cnt    (res_cnt),
		.pop_ready  (m_tready),
		.can_load   (can_load),
		.head_valid (m_tvalid),
		.head       (head)
	);

	// Pack the head result onto the output bus
	assign m_tdata = {2'b00, head.number_overflow, head.number_value, head.token_length,
		head.short_length, head.short_text, head.token_type, head.value_char};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

>>> tb/tb_source_token_lexer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_token_lexer_unit
// Self-checking bench for the character-serial token lexer. A short directed
// text covers every token type, the two-character operators, comments, the
// undefined bytes and the flush at end of input. Random token-shaped text
// follows: identifiers, short and saturating numbers, strings, operators,
// comments, whitespace, noise bytes and end markers. A behavioral lexer
// predicts the results of each accepted byte, and every output transfer is
// compared field by field in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_source_token_lexer_unit;
	import stl_pkg::*;

	// Source byte as it waits for the driver
	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
	} src_item_t;

	// One predicted output transfer
	typedef struct packed {
		logic        kind;
		logic [7:0]  vchar;
		logic [2:0]  ttype;
		logic [15:0] stext;
		logic [1:0]  slen;
		logic [15:0] tlen;
		logic [63:0] nval;
		logic        novf;
		logic        last;
	} lex_result_t;

	typedef enum logic [2:0] {
		LX_IDLE,
		LX_IDENT,
		LX_NUM,
		LX_STR,
		LX_OP,
		LX_COMMENT
	} lex_mode_e;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b1;
	logic [111:0] m_tdata;
	logic         m_tuser;
	logic         m_tlast;

	src_item_t   source_bytes_q[$];
	lex_result_t expected_results_q[$];
	lex_result_t step_results_q[$];

	// Predicted lexer state
	lex_mode_e   lx_mode = LX_IDLE;
	logic        lx_backtick = 1'b0;
	logic [15:0] op_text = '0;
	logic [1:0]  op_len = '0;
	logic [63:0] num_acc = '0;
	logic        num_ovf = 1'b0;
	logic [15:0] val_count = '0;
	logic        star_seen = 1'b0;

	int unsigned bytes_sent = 0;
	int unsigned end_markers = 0;
	int unsigned results_checked = 0;
	int unsigned tokens_closed = 0;
	int unsigned saturated_numbers = 0;
	int unsigned check_failures = 0;

	src_item_t   src_next;
	int unsigned src_hold = 0;
	bit          src_burst = 1'b0;
	int unsigned sink_hold = 0;
	bit          sink_burst = 1'b0;

	source_token_lexer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Character classes
	// ------------------------------------------------------------------
	function automatic bit in_set(input string s, input logic [7:0] c);
		for (int i = 0; i < s.len(); i++) begin
			if (s[i] == c) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
	endfunction

	// Second byte that makes a two-character operator
	function automatic bit pairs_with(input logic [7:0] first, input logic [7:0] c);
		case (first)
			CH_EQ:    return (c == CH_EQ) || (c == CH_GT);
			CH_PLUS:  return (c == CH_EQ) || (c == CH_PLUS);
			CH_MINUS: return (c == CH_EQ) || (c == CH_MINUS) || (c == CH_GT);
			default:  return c == CH_EQ;
		endcase
	endfunction

	function automatic lex_result_t token_res(input logic [2:0] tt, input logic [15:0] txt,
		input logic [1:0] tl, input logic [15:0] len, input logic [63:0] num,
		input logic ovf);
		lex_result_t r;
		r = '0;
		r.kind  = RK_TOKEN;
		r.ttype = tt;
		r.stext = txt;
		r.slen  = tl;
		r.tlen  = len;
		r.nval  = num;
		r.novf  = ovf;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Behavioral lexer
	// ------------------------------------------------------------------
	task automatic add_value(input logic [7:0] c);
		lex_result_t r;
		r = '0;
		r.kind  = RK_VALUE;
		r.vchar = c;
		step_results_q.push_back(r);
		if (val_count != LEN_MAX) val_count++;
	endtask

	// Saturate the decimal value once it would pass 64 bits
	task automatic add_digit(input logic [63:0] d);
		if (num_ovf || num_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
			num_acc = 64'hFFFF_FFFF_FFFF_FFFF;
			num_ovf = 1'b1;
		end else begin
			num_acc = num_acc * 64'd10 + d;
		end
	endtask

	task automatic clear_lexer();
		lx_mode     = LX_IDLE;
		lx_backtick = 1'b0;
		op_text     = '0;
		op_len      = '0;
		num_acc     = '0;
		num_ovf     = 1'b0;
		val_count   = '0;
		star_seen   = 1'b0;
	endtask

	// Close an identifier, number or operator that is still open
	task automatic close_pending();
		case (lx_mode)
			LX_IDENT: step_results_q.push_back(token_res(TT_IDENT, '0, '0, val_count, '0, 1'b0));
			LX_NUM:   step_results_q.push_back(token_res(TT_NUMBER, '0, '0, val_count,
				num_acc, num_ovf));
			LX_OP:    step_results_q.push_back(token_res(TT_OPERATOR, op_text, op_len, '0, '0,
				1'b0));
			default: ;
		endcase
	endtask

	// Lex one byte from the state between tokens
	task automatic start_token(input logic [7:0] c);
		clear_lexer();
		if (in_set("(){}[]:,;~^#$?!@.&|", c)) begin
			step_results_q.push_back(token_res(TT_PUNCT, {8'h00, c}, 2'd1, '0, '0, 1'b0));
		end else if (in_set("=<>+-*/%", c)) begin
			lx_mode = LX_OP;
			op_text = {8'h00, c};
			op_len  = 2'd1;
		end else if (c == CH_BTICK || c == CH_DQUOTE) begin
			lx_mode     = LX_STR;
			lx_backtick = (c == CH_BTICK);
		end else if (is_blank(c)) begin
			// skip
		end else if (is_num(c)) begin
			lx_mode = LX_NUM;
			add_digit(64'(c) - 64'h30);
			add_value(c);
		end else if (is_letter(c) || c == CH_UNDER) begin
			lx_mode = LX_IDENT;
			add_value(c);
		end else begin
			step_results_q.push_back(token_res(TT_UNDEF, {8'h00, c}, 2'd1, '0, '0, 1'b0));
		end
	endtask

	task automatic lex_byte(input logic [7:0] c);
		case (lx_mode)
			LX_IDENT: begin
				if (is_letter(c) || is_num(c) || c == CH_UNDER) begin
					add_value(c);
				end else begin
					close_pending();
					start_token(c);
				end
			end
			LX_NUM: begin
				if (is_num(c)) begin
					add_digit(64'(c) - 64'h30);
					add_value(c);
				end else begin
					close_pending();
					start_token(c);
				end
			end
			LX_STR: begin
				if (c == (lx_backtick ? CH_BTICK : CH_DQUOTE)) begin
					step_results_q.push_back(token_res(lx_backtick ? TT_FORMAT : TT_STRING,
						'0, '0, val_count, '0, 1'b0));
					clear_lexer();
				end else begin
					add_value(c);
				end
			end
			LX_OP: begin
				if (op_len == 2'd1 && op_text[7:0] == CH_SLASH && c == CH_STAR) begin
					clear_lexer();
					lx_mode = LX_COMMENT;
				end else if (op_len == 2'd1 && pairs_with(op_text[7:0], c)) begin
					op_text[15:8] = c;
					op_len        = 2'd2;
				end else begin
					close_pending();
					start_token(c);
				end
			end
			LX_COMMENT: begin
				if (star_seen && c == CH_SLASH) clear_lexer();
				else star_seen = (c == CH_STAR);
			end
			default: start_token(c);
		endcase
	endtask

	// Work out the results of one accepted byte and queue them
	task automatic predict_results(input logic [7:0] c, input logic eoi);
		step_results_q.delete();
		if (eoi) begin
			close_pending();
			clear_lexer();
			step_results_q.push_back(token_res(TT_END, '0, '0, '0, '0, 1'b0));
		end else begin
			lex_byte(c);
		end
		if (step_results_q.size() != 0) step_results_q[step_results_q.size() - 1].last = 1'b1;
		foreach (step_results_q[i]) expected_results_q.push_back(step_results_q[i]);
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [63:0] exp,
		input logic [63:0] act);
		if (exp !== act) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, exp, act);
			check_failures++;
		end
	endtask

	task automatic check_result();
		lex_result_t e;
		if (expected_results_q.size() == 0) begin
			$error("result with nothing expected: kind %0d data 0x%0h", m_tuser, m_tdata);
			check_failures++;
			return;
		end
		e = expected_results_q.pop_front();
		check_field("result_kind", 64'(e.kind), 64'(m_tuser));
		check_field("value_char", 64'(e.vchar), 64'(m_tdata[7:0]));
		check_field("token_type", 64'(e.ttype), 64'(m_tdata[10:8]));
		check_field("short_text", 64'(e.stext), 64'(m_tdata[26:11]));
		check_field("short_length", 64'(e.slen), 64'(m_tdata[28:27]));
		check_field("token_length", 64'(e.tlen), 64'(m_tdata[44:29]));
		check_field("number_value", e.nval, m_tdata[108:45]);
		check_field("number_overflow", 64'(e.novf), 64'(m_tdata[109]));
		check_field("last_result", 64'(e.last), 64'(m_tlast));
		results_checked++;
		if (e.kind == RK_TOKEN) tokens_closed++;
		if (e.novf) saturated_numbers++;
	endtask

	// ------------------------------------------------------------------
	// Driver: one byte per transfer, random gap after each
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
			s_tlast  <= 1'b0;
			src_hold = 0;
		end else begin
			// predict what the finished transfer causes
			if (s_tvalid && s_tready) begin
				predict_results(s_tdata, s_tlast);
				bytes_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_hold != 0) begin
					src_hold--;
					s_tvalid <= 1'b0;
				end else if (source_bytes_q.size() != 0) begin
					src_next = source_bytes_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= src_next.ch;
					s_tlast  <= src_next.eoi;
					if ($urandom_range(0, 29) == 0) src_burst = !src_burst;
					src_hold = src_burst ? 0 : $urandom_range(0, 19);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each result, then stall for a random count
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b1;
			sink_hold = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result();
				if ($urandom_range(0, 29) == 0) sink_burst = !sink_burst;
				sink_hold = sink_burst ? 0 : $urandom_range(0, 19);
				m_tready <= (sink_hold == 0);
			end else if (sink_hold != 0) begin
				sink_hold--;
				m_tready <= (sink_hold == 0);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_char(input logic [7:0] c);
		source_bytes_q.push_back('{ch: c, eoi: 1'b0});
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i]);
	endtask

	task automatic push_eoi(input logic [7:0] c);
		source_bytes_q.push_back('{ch: c, eoi: 1'b1});
		end_markers++;
	endtask

	function automatic logic [7:0] pick_from(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 8) == 0) return CH_UNDER;
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	task automatic push_identifier();
		push_char(rand_letter());
		repeat ($urandom_range(0, 8)) begin
			push_char($urandom_range(0, 3) == 0 ? rand_digit() : rand_letter());
		end
	endtask

	task automatic push_number();
		case ($urandom_range(0, 5))
			0:       push_text("18446744073709551615");
			1:       push_text("18446744073709551616");
			2:       repeat ($urandom_range(19, 24)) push_char(rand_digit());
			default: repeat ($urandom_range(1, 6)) push_char(rand_digit());
		endcase
	endtask

	// Mostly closed strings; the open ones end at a later quote or marker
	task automatic push_string();
		logic [7:0] quote;
		logic [7:0] c;
		quote = $urandom_range(0, 1) ? CH_BTICK : CH_DQUOTE;
		push_char(quote);
		repeat ($urandom_range(0, 6)) begin
			c = 8'($urandom_range(0, 255));
			if (c == quote) c = 8'h41;
			push_char(c);
		end
		if ($urandom_range(0, 7) != 0) push_char(quote);
	endtask

	task automatic push_operator();
		push_char(pick_from("=<>+-*/%"));
		if ($urandom_range(0, 1)) push_char(pick_from("=>+-"));
	endtask

	// Comment body leans on stars to hit the close check
	task automatic push_comment();
		push_char(CH_SLASH);
		push_char(CH_STAR);
		repeat ($urandom_range(0, 6)) begin
			push_char($urandom_range(0, 2) == 0 ? CH_STAR : 8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 7) != 0) push_text("*/");
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		// directed: every token type, operator pairs, comment, flush at end
		push_text("_aZ9(-->5\"q\"");
		push_char(CH_BTICK);
		push_char(CH_BTICK);
		push_text("/**/");
		push_char(8'h00);
		push_char(8'hFF);
		push_char(CH_PLUS);
		push_eoi(8'hFF);
		push_text("\"a");
		push_eoi(8'h00);

		// random token-shaped text
		while (source_bytes_q.size() < 345) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: push_identifier();
				4, 5, 6:    push_number();
				7, 8:       push_string();
				9, 10, 11:  push_operator();
				12:         push_char(pick_from("(){}[]:,;~^#$?!@.&|"));
				13:         push_comment();
				14, 15:     push_char(pick_from("\t\n\v\f\r "));
				16, 17:     push_char(8'($urandom_range(0, 255)));
				default:    push_eoi(8'($urandom_range(0, 255)));
			endcase
			if ($urandom_range(0, 3) == 0) push_char(8'h20);
		end
		push_eoi(8'($urandom_range(0, 255)));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// drain, then allow for late or extra results
		while (source_bytes_q.size() != 0 || s_tvalid || expected_results_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("Lexed %0d source bytes with %0d end markers; checked %0d results.",
			bytes_sent, end_markers, results_checked);
		$display("Closed %0d tokens, %0d of them saturated numbers.",
			tokens_closed, saturated_numbers);
		if (check_failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Timeout with %0d results still expected", expected_results_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
